// ===== hdl/mqlb_pkg.sv =====
`timescale 1ns / 1ps

package mqlb_pkg;

    // Default sizes of the shared slot store and of the queue table
    localparam int SLOTS_DEF      = 16;
    localparam int NUM_QUEUES_DEF = 8;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int QIDX_W   = 3;
    localparam int ACTIVE_W = 4;

    // Reset value of the active queue count
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    // Request kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_INVALID   = 2'd1;
    localparam status_t ST_OVERFLOW  = 2'd2;
    localparam status_t ST_UNDERFLOW = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // take a new request and issue the store reads
        logic finish;   // update pointers and links, register the result
    } mqlb_cmd_t;

endpackage

// ===== hdl/mqlb_ctrl.sv =====
`timescale 1ns / 1ps

module mqlb_ctrl
    import mqlb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output mqlb_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    // Advance on a new request, return to idle after the update cycle
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    // Drive datapath commands
    always_comb
    begin
        cmd.capture = start && (state_reg == S_IDLE);
        cmd.finish  = (state_reg == S_EXEC);
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

endmodule

// ===== hdl/mqlb_datapath.sv =====
`timescale 1ns / 1ps

module mqlb_datapath
    import mqlb_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int NUM_QUEUES = NUM_QUEUES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mqlb_cmd_t                  cmd,
    input  logic                       kind,
    input  logic        [QIDX_W-1:0]   queue_index,
    input  logic signed [WORD_W-1:0]   write_value,
    input  logic                       cfg_wr_en,
    input  logic        [ACTIVE_W-1:0] cfg_wr_data,
    output status_t                    status,
    output logic signed [WORD_W-1:0]   read_value
);

    localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW   = $clog2(SLOTS + 1);
    localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QXW  = (QW > QIDX_W) ? QW : QIDX_W;
    localparam logic [PW-1:0] NULL_PTR = PW'(SLOTS);

    // Slot stores
    logic [WORD_W-1:0] data_mem [SLOTS];
    logic [PW-1:0]     link_mem [SLOTS];

    // Queue table and free list
    logic [PW-1:0]       head_reg [NUM_QUEUES];
    logic [PW-1:0]       tail_reg [NUM_QUEUES];
    logic [PW-1:0]       free_head_reg;
    logic [PW-1:0]       fresh_reg;   // lowest slot never handed out
    logic [ACTIVE_W-1:0] active_reg;

    // Captured request
    logic              kind_reg;
    logic [QW-1:0]     q_reg;
    logic [PW-1:0]     slot_reg;
    status_t           err_reg;
    logic [PW-1:0]     link_rd_reg;
    logic [WORD_W-1:0] data_rd_reg;

    // Result registers
    status_t           status_reg;
    logic [WORD_W-1:0] read_value_reg;

    logic [QXW-1:0] q_ext;
    logic [QW-1:0]  q_idx;
    logic           q_valid;
    status_t        req_status;
    logic [PW-1:0]  slot_sel;
    logic           commit;
    logic           link_we;
    logic [PW-1:0]  link_wa;
    logic [PW-1:0]  link_wd;

    // Check the request and pick the slot it touches
    always_comb
    begin
        q_ext    = QXW'(queue_index);
        q_idx    = q_ext[QW-1:0];
        q_valid  = ({1'b0, queue_index} < active_reg) && (int'(queue_index) < NUM_QUEUES);
        slot_sel = (kind == KIND_POP) ? head_reg[q_idx] : free_head_reg;
        if (!q_valid)
        begin
            req_status = ST_INVALID;
        end
        else if ((kind == KIND_PUSH) && (free_head_reg >= NULL_PTR))
        begin
            req_status = ST_OVERFLOW;
        end
        else if ((kind == KIND_POP) && (head_reg[q_idx] >= NULL_PTR))
        begin
            req_status = ST_UNDERFLOW;
        end
        else
        begin
            req_status = ST_OK;
        end
    end

    // Select the single link write of the update cycle
    always_comb
    begin
        commit = cmd.finish && (err_reg == ST_OK);
        if (kind_reg == KIND_POP)
        begin
            link_we = 1'b1;
            link_wa = slot_reg;
            link_wd = free_head_reg;
        end
        else
        begin
            link_we = (head_reg[q_reg] < NULL_PTR) && (tail_reg[q_reg] < NULL_PTR);
            link_wa = tail_reg[q_reg];
            link_wd = slot_reg;
        end
    end

    // Read both stores on capture, store the pushed word, write links on update
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            link_rd_reg <= link_mem[slot_sel[AW-1:0]];
            data_rd_reg <= data_mem[slot_sel[AW-1:0]];
            if ((kind == KIND_PUSH) && (req_status == ST_OK))
            begin
                data_mem[slot_sel[AW-1:0]] <= write_value;
            end
        end
        if (commit && link_we)
        begin
            link_mem[link_wa[AW-1:0]] <= link_wd;
        end
    end

    // Hold the captured request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            q_reg    <= q_idx;
            slot_reg <= slot_sel;
        end
        if (cmd.finish)
        begin
            status_reg <= err_reg;
            if (kind_reg == KIND_POP)
            begin
                read_value_reg <= (err_reg == ST_OK) ? data_rd_reg : '1;
            end
            else
            begin
                read_value_reg <= '0;
            end
        end
    end

    // Update queue pointers, free list and the active count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= NULL_PTR;
                tail_reg[i] <= NULL_PTR;
            end
            free_head_reg <= '0;
            fresh_reg     <= '0;
            active_reg    <= ACTIVE_RESET;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                active_reg <= cfg_wr_data;
            end
            if (cmd.capture)
            begin
                err_reg <= req_status;
            end
            if (commit)
            begin
                if (kind_reg == KIND_PUSH)
                begin
                    // never-used slots chain to the next one in order
                    if (slot_reg == fresh_reg)
                    begin
                        free_head_reg <= slot_reg + PW'(1);
                        fresh_reg     <= fresh_reg + PW'(1);
                    end
                    else
                    begin
                        free_head_reg <= link_rd_reg;
                    end
                    if (head_reg[q_reg] >= NULL_PTR)
                    begin
                        head_reg[q_reg] <= slot_reg;
                    end
                    tail_reg[q_reg] <= slot_reg;
                end
                else
                begin
                    // the tail slot ends the queue
                    head_reg[q_reg] <= (slot_reg == tail_reg[q_reg]) ? NULL_PTR : link_rd_reg;
                    free_head_reg   <= slot_reg;
                end
            end
        end
    end

    assign status     = status_reg;
    assign read_value = $signed(read_value_reg);

endmodule

// ===== hdl/multi_queue_linked_buffer.sv =====
// A request taken at a clock edge has the link and data stores read into registers; then, in
// the update state, pointers and links are updated and the result is registered, with done
// high for one cycle. A new request is taken only after the update; busy is high during it.
// Results cannot be stalled by the receiver. Reset (rst_n low, asynchronous) empties all queues,
// restores the full free list and sets the active queue count to 8; no clearing pass is run.
`timescale 1ns / 1ps

module multi_queue_linked_buffer
    import mqlb_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int NUM_QUEUES = NUM_QUEUES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       kind,
    input  logic        [QIDX_W-1:0]   queue_index,
    input  logic signed [WORD_W-1:0]   write_value,
    input  logic                       cfg_wr_en,
    input  logic        [ACTIVE_W-1:0] cfg_wr_data,
    output logic                       done,
    output logic        [1:0]          status,
    output logic signed [WORD_W-1:0]   read_value
);

    mqlb_cmd_t cmd;
    status_t   status_w;

    // Sequence each request
    mqlb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Stores, pointers and result registers
    mqlb_datapath #(
        .SLOTS      (SLOTS),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (kind),
        .queue_index (queue_index),
        .write_value (write_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status_w),
        .read_value  (read_value)
    );

    assign status = status_w;

endmodule
